/* rtl/rotated_sprite_alpha_blend_defines.svh */
// Assertion macros for the rotated sprite blender.
// Included by files that check their own logic; needs no other file.
`ifndef ROTATED_SPRITE_ALPHA_BLEND_DEFINES_SVH
`define ROTATED_SPRITE_ALPHA_BLEND_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RSAB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RSAB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RSAB_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RSAB_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/rsab_pkg.sv */
// Shared types, constants and helpers of the rotated sprite blender.
// No dependencies.
`timescale 1ns / 1ps

package rsab_pkg;

   localparam int PIX_W    = 32;
   localparam int ANGLE_W  = 16;
   localparam int PIVOT_W  = 9;
   localparam int COORD_W  = 10;
   localparam int SADDR_W  = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ANGLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ANGLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_COL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_ROW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ROW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_COLS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_ROWS = 3'd7;

   // reset values
   localparam logic [ANGLE_W-1:0] COS_RESET    = 16'd16384;
   localparam logic [ANGLE_W-1:0] SIN_RESET    = 16'd0;
   localparam logic [PIVOT_W-1:0] PIVOT_RESET  = 9'd0;
   localparam logic [COORD_W-1:0] CENTER_RESET = 10'd240;
   localparam logic [COORD_W-1:0] SIZE_RESET   = 10'd64;

   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_BLEND = 1'b1
   } req_kind_type;

   // one access to the sprite store per cycle
   typedef struct packed {
      logic en;
      logic wr;
   } store_cmd_type;

   // floor(x / 255) for x up to 255*255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

endpackage

/* rtl/rsab_store.sv */
// Sprite store: single-port synchronous RAM, registered read data.
// Depends on rsab_pkg.
`timescale 1ns / 1ps

module rsab_store #(
   parameter int DEPTH = 32768
) (
   input  logic                          clock,
   input  rsab_pkg::store_cmd_type       cmd,
   input  logic [$clog2(DEPTH)-1:0]      addr,
   input  logic [rsab_pkg::PIX_W-1:0]    wdata,
   output logic [rsab_pkg::PIX_W-1:0]    rdata
);
   import rsab_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rdata_ff;

   // read data only moves on a read, so it holds while the reader stalls
   always_ff @(posedge clock) begin
      if (cmd.en) begin
         if (cmd.wr) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/rotated_sprite_alpha_blend.sv */
// Rotated sprite alpha blender, top level.
// Depends on rsab_pkg, rsab_store and rotated_sprite_alpha_blend_defines.svh.
`timescale 1ns / 1ps
`include "rotated_sprite_alpha_blend_defines.svh"

// Loads an ARGB8888 sprite into an internal store one word at a time and
// blends it, rotated, over a stream of destination pixels. A request word
// with req_type load writes req_sprite_word at req_sprite_addr (ignored at
// or beyond SPRITE_WORDS) and gives no response. A blend word inverse-
// rotates (dest_col, dest_row) about (center_col, center_row) with the Q2.14
// cos/sin registers, rounds half away-ish (add 0.5, truncate toward zero),
// adds the pivot and fetches row*sprite_cols+col. Outside the sprite, beyond
// the store or at source alpha 0 the response returns dest_pixel with
// write_enable low; alpha 255 returns the sprite word; otherwise each color
// channel is floor((s*a + d*(255-a))/255) with alpha forced to 0xFF.
// Throughput is one word per clock while no stall holds the pipeline, loads
// and blends mixed freely. Seven stage registers s1..s7 feed the response
// register that drives rsp_valid; the first is loaded at the accepting edge.
// The rate is set by the store, which has one port: every word makes at
// most one access to it, in the same pipeline stage, so loads and blends
// see the store in request order with no forwarding. Each stage holds its
// word independently, so requests keep flowing into empty stages while a
// response waits on rsp_stall. Store contents are undefined until loaded;
// there is no clearing pass. The user must write registers only while
// idle; the block itself does not enforce it.
module rotated_sprite_alpha_blend #(
   parameter int SPRITE_WORDS = 32768
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [rsab_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [rsab_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [rsab_pkg::SADDR_W-1:0]      req_sprite_addr,
   input  logic [rsab_pkg::PIX_W-1:0]        req_sprite_word,
   input  logic [rsab_pkg::COORD_W-1:0]      req_dest_col,
   input  logic [rsab_pkg::COORD_W-1:0]      req_dest_row,
   input  logic [rsab_pkg::PIX_W-1:0]        req_dest_pixel,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rsab_pkg::PIX_W-1:0]        rsp_out_pixel,
   output logic                              rsp_write_enable
);
   import rsab_pkg::*;

   localparam int AW = $clog2(SPRITE_WORDS);
   localparam logic [20:0] STORE_LIMIT = 21'(SPRITE_WORDS);

   // ---------------- configuration registers ----------------
   logic [ANGLE_W-1:0] cos_ff, sin_ff;
   logic [PIVOT_W-1:0] pivot_col_ff, pivot_row_ff;
   logic [COORD_W-1:0] center_col_ff, center_row_ff;
   logic [COORD_W-1:0] sprite_cols_ff, sprite_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff         <= COS_RESET;
         sin_ff         <= SIN_RESET;
         pivot_col_ff   <= PIVOT_RESET;
         pivot_row_ff   <= PIVOT_RESET;
         center_col_ff  <= CENTER_RESET;
         center_row_ff  <= CENTER_RESET;
         sprite_cols_ff <= SIZE_RESET;
         sprite_rows_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_COS_ANGLE:   cos_ff         <= csr_wdata;
            CSR_SIN_ANGLE:   sin_ff         <= csr_wdata;
            CSR_PIVOT_COL:   pivot_col_ff   <= csr_wdata[PIVOT_W-1:0];
            CSR_PIVOT_ROW:   pivot_row_ff   <= csr_wdata[PIVOT_W-1:0];
            CSR_CENTER_COL:  center_col_ff  <= csr_wdata[COORD_W-1:0];
            CSR_CENTER_ROW:  center_row_ff  <= csr_wdata[COORD_W-1:0];
            CSR_SPRITE_COLS: sprite_cols_ff <= csr_wdata[COORD_W-1:0];
            CSR_SPRITE_ROWS: sprite_rows_ff <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage readiness ----------------
   // A stage takes a new word when it is empty or its word moves on.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s5_valid_ff, s6_valid_ff, s7_valid_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy_out;

   assign rdy_out = !rsp_valid_ff || !rsp_stall;
   assign rdy7    = !s7_valid_ff || rdy_out;
   assign rdy6    = !s6_valid_ff || rdy7;
   assign rdy5    = !s5_valid_ff || rdy6;
   assign rdy4    = !s4_valid_ff || rdy5;
   assign rdy3    = !s3_valid_ff || rdy4;
   assign rdy2    = !s2_valid_ff || rdy3;
   assign rdy1    = !s1_valid_ff || rdy2;

   assign req_stall = !rdy1;

   // ---------------- s1: request, offset from center ----------------
   // pix carries the load word or the destination color, by kind
   req_kind_type            s1_kind_ff;
   logic [SADDR_W-1:0]      s1_addr_ff;
   logic [PIX_W-1:0]        s1_pix_ff, s1_pix_in;
   logic signed [10:0]      s1_fx_ff, s1_fy_ff, s1_fx_in, s1_fy_in;

   always_comb begin
      s1_fx_in  = $signed({1'b0, req_dest_col}) - $signed({1'b0, center_col_ff});
      s1_fy_in  = $signed({1'b0, req_dest_row}) - $signed({1'b0, center_row_ff});
      s1_pix_in = (req_kind_type'(req_type) == REQ_BLEND) ? req_dest_pixel
                                                          : req_sprite_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rdy1) begin
         s1_valid_ff <= req_valid;
         s1_kind_ff  <= req_kind_type'(req_type);
         s1_addr_ff  <= req_sprite_addr;
         s1_pix_ff   <= s1_pix_in;
         s1_fx_ff    <= s1_fx_in;
         s1_fy_ff    <= s1_fy_in;
      end
   end

   // ---------------- s2: four rotation products ----------------
   req_kind_type            s2_kind_ff;
   logic [SADDR_W-1:0]      s2_addr_ff;
   logic [PIX_W-1:0]        s2_pix_ff;
   logic signed [26:0]      s2_xc_ff, s2_ys_ff, s2_yc_ff, s2_xs_ff;
   logic signed [26:0]      s2_xc_in, s2_ys_in, s2_yc_in, s2_xs_in;
   logic signed [ANGLE_W-1:0] cos_s, sin_s;

   always_comb begin
      cos_s    = $signed(cos_ff);
      sin_s    = $signed(sin_ff);
      s2_xc_in = s1_fx_ff * cos_s;
      s2_ys_in = s1_fy_ff * sin_s;
      s2_yc_in = s1_fy_ff * cos_s;
      s2_xs_in = s1_fx_ff * sin_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff;
         s2_kind_ff  <= s1_kind_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_pix_ff   <= s1_pix_ff;
         s2_xc_ff    <= s2_xc_in;
         s2_ys_ff    <= s2_ys_in;
         s2_yc_ff    <= s2_yc_in;
         s2_xs_ff    <= s2_xs_in;
      end
   end

   // ---------------- s3: Q.14 sums plus one half ----------------
   req_kind_type            s3_kind_ff;
   logic [SADDR_W-1:0]      s3_addr_ff;
   logic [PIX_W-1:0]        s3_pix_ff;
   logic signed [27:0]      s3_tu_ff, s3_tv_ff, s3_tu_in, s3_tv_in;

   always_comb begin
      s3_tu_in = 28'(s2_xc_ff) + 28'(s2_ys_ff) + 28'sd8192;
      s3_tv_in = 28'(s2_yc_ff) - 28'(s2_xs_ff) + 28'sd8192;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (rdy3) begin
         s3_valid_ff <= s2_valid_ff;
         s3_kind_ff  <= s2_kind_ff;
         s3_addr_ff  <= s2_addr_ff;
         s3_pix_ff   <= s2_pix_ff;
         s3_tu_ff    <= s3_tu_in;
         s3_tv_ff    <= s3_tv_in;
      end
   end

   // ---------------- s4: truncate toward zero, add pivot ----------------
   req_kind_type            s4_kind_ff;
   logic [SADDR_W-1:0]      s4_addr_ff;
   logic [PIX_W-1:0]        s4_pix_ff;
   logic [13:0]             s4_sx_ff, s4_sy_ff, s4_sx_in, s4_sy_in;
   logic                    fix_u, fix_v;

   // arithmetic shift floors; a negative value with a fraction steps back up
   always_comb begin
      fix_u    = s3_tu_ff[27] && (s3_tu_ff[13:0] != 14'd0);
      fix_v    = s3_tv_ff[27] && (s3_tv_ff[13:0] != 14'd0);
      s4_sx_in = 14'(pivot_col_ff) + s3_tu_ff[27:14] + 14'(fix_u);
      s4_sy_in = 14'(pivot_row_ff) + s3_tv_ff[27:14] + 14'(fix_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (rdy4) begin
         s4_valid_ff <= s3_valid_ff;
         s4_kind_ff  <= s3_kind_ff;
         s4_addr_ff  <= s3_addr_ff;
         s4_pix_ff   <= s3_pix_ff;
         s4_sx_ff    <= s4_sx_in;
         s4_sy_ff    <= s4_sy_in;
      end
   end

   // ---------------- s5: bounds check, row offset ----------------
   req_kind_type            s5_kind_ff;
   logic [SADDR_W-1:0]      s5_addr_ff;
   logic [PIX_W-1:0]        s5_pix_ff;
   logic                    s5_inside_ff, s5_inside_in;
   logic [19:0]             s5_rowoff_ff, s5_rowoff_in;
   logic [COORD_W-1:0]      s5_sx_ff;

   always_comb begin
      s5_inside_in = !s4_sx_ff[13] && (s4_sx_ff < 14'(sprite_cols_ff)) &&
                     !s4_sy_ff[13] && (s4_sy_ff < 14'(sprite_rows_ff));
      s5_rowoff_in = 20'(s4_sy_ff[COORD_W-1:0]) * 20'(sprite_cols_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (rdy5) begin
         s5_valid_ff  <= s4_valid_ff;
         s5_kind_ff   <= s4_kind_ff;
         s5_addr_ff   <= s4_addr_ff;
         s5_pix_ff    <= s4_pix_ff;
         s5_inside_ff <= s5_inside_in;
         s5_rowoff_ff <= s5_rowoff_in;
         s5_sx_ff     <= s4_sx_ff[COORD_W-1:0];
      end
   end

   // ---------------- store access (s5 -> s6) ----------------
   // Loads write and blends read here in order, one word per cycle unless s6
   // is held, so a blend always sees every earlier load and none of the later ones.
   logic [20:0]             full_addr, store_addr21;
   logic                    blend_hit, load_ok;
   store_cmd_type           store_cmd;
   logic [PIX_W-1:0]        store_rdata;

   always_comb begin
      full_addr    = 21'(s5_rowoff_ff) + 21'(s5_sx_ff);
      blend_hit    = s5_inside_ff && (full_addr < STORE_LIMIT);
      load_ok      = 21'(s5_addr_ff) < STORE_LIMIT;
      store_addr21 = (s5_kind_ff == REQ_BLEND) ? full_addr : 21'(s5_addr_ff);
      store_cmd.wr = (s5_kind_ff == REQ_LOAD);
      store_cmd.en = s5_valid_ff && rdy6 &&
                     ((s5_kind_ff == REQ_BLEND) ? blend_hit : load_ok);
   end

   rsab_store #(
      .DEPTH (SPRITE_WORDS)
   ) u_store (
      .clock (clock),
      .cmd   (store_cmd),
      .addr  (store_addr21[AW-1:0]),
      .wdata (s5_pix_ff),
      .rdata (store_rdata)
   );

   // ---------------- s6: sprite word arrives ----------------
   // loads end here and leave a bubble
   logic                    s6_hit_ff;
   logic [PIX_W-1:0]        s6_dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (rdy6) begin
         s6_valid_ff <= s5_valid_ff && (s5_kind_ff == REQ_BLEND);
         s6_hit_ff   <= blend_hit;
         s6_dest_ff  <= s5_pix_ff;
      end
   end

   // ---------------- s7: channel products ----------------
   logic [7:0]              src_a, inv_a;
   logic                    s7_write_ff, s7_write_in;
   logic                    s7_opaque_ff, s7_opaque_in;
   logic [PIX_W-1:0]        s7_src_ff, s7_dest_ff;
   logic [15:0]             s7_r_ff, s7_g_ff, s7_b_ff;
   logic [15:0]             s7_r_in, s7_g_in, s7_b_in;

   always_comb begin
      src_a        = store_rdata[31:24];
      inv_a        = ALPHA_OPAQUE - src_a;
      s7_write_in  = s6_hit_ff && (src_a != ALPHA_CLEAR);
      s7_opaque_in = (src_a == ALPHA_OPAQUE);
      s7_r_in = 16'(store_rdata[23:16]) * 16'(src_a) +
                16'(s6_dest_ff[23:16]) * 16'(inv_a);
      s7_g_in = 16'(store_rdata[15:8]) * 16'(src_a) +
                16'(s6_dest_ff[15:8]) * 16'(inv_a);
      s7_b_in = 16'(store_rdata[7:0]) * 16'(src_a) +
                16'(s6_dest_ff[7:0]) * 16'(inv_a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (rdy7) begin
         s7_valid_ff  <= s6_valid_ff;
         s7_write_ff  <= s7_write_in;
         s7_opaque_ff <= s7_opaque_in;
         s7_src_ff    <= store_rdata;
         s7_dest_ff   <= s6_dest_ff;
         s7_r_ff      <= s7_r_in;
         s7_g_ff      <= s7_g_in;
         s7_b_ff      <= s7_b_in;
      end
   end

   // ---------------- output register: /255 and select ----------------
   logic [PIX_W-1:0]        rsp_pixel_ff, rsp_pixel_in;
   logic                    rsp_we_ff;

   always_comb begin
      if (!s7_write_ff) begin
         rsp_pixel_in = s7_dest_ff;
      end else if (s7_opaque_ff) begin
         rsp_pixel_in = s7_src_ff;
      end else begin
         rsp_pixel_in = {ALPHA_OPAQUE, div255(s7_r_ff), div255(s7_g_ff),
                         div255(s7_b_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy_out) begin
         rsp_valid_ff <= s7_valid_ff;
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_we_ff    <= s7_write_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_pixel    = rsp_pixel_ff;
   assign rsp_write_enable = rsp_we_ff;

   // ---------------- assertions ----------------
   `RSAB_ASSERT_IMP(a_written_opaque, clock, reset, rsp_valid_ff && rsp_we_ff, rsp_pixel_ff[31:24] == ALPHA_OPAQUE, "written pixel is not opaque")
   `RSAB_ASSERT_NXT(a_read_hold, clock, reset, s6_valid_ff && s6_hit_ff && !rdy6, s6_valid_ff && $stable(store_rdata), "store read data moved under a held blend")
   `RSAB_ASSERT_NXT(a_load_silent, clock, reset, s5_valid_ff && (s5_kind_ff == REQ_LOAD) && rdy6, !s6_valid_ff, "load word turned into a response")

endmodule
